[rtl/bup4_pkg.sv]
package bup4_pkg;

    // Fixed field widths.
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 13;
    localparam int CFGW_W  = 11;
    localparam int CFGH_W  = 13;
    localparam int CFGD_W  = 13;
    localparam int OROW_W  = 14;
    localparam int OCOL_W  = 12;
    localparam int CMP_W   = 14;

    // Design defaults and limits.
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int WIDTH_RST     = 640;
    localparam int HEIGHT_RST    = 480;

    // Job queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    // Block codes, one bit of the job mask each.
    localparam int BLK_INNER  = 0;  // upper-left block, all four neighbors present
    localparam int BLK_RIGHT  = 1;  // right edge, column repeated
    localparam int BLK_BOTTOM = 2;  // bottom edge, row repeated
    localparam int BLK_CORNER = 3;  // bottom-right corner, pixel repeated

    // One classified input pixel with the neighbors it needs.
    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] ul;
        logic [PIX_W-1:0] prev;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [3:0]       mask;
    } t_job;

    // Quarter-step interpolation; each weighted term is truncated on its own.
    function automatic logic [CHAN_W-1:0] f_lerp(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b,
                                                 input logic [1:0]        d);
        logic [CHAN_W+2:0] pa;
        logic [CHAN_W+2:0] pb;
        logic [CHAN_W:0]   s;
        pa = {3'b000, a} * (11'd4 - {9'd0, d});
        pb = {3'b000, b} * {9'd0, d};
        s  = {1'b0, pa[CHAN_W+1:2]} + {1'b0, pb[CHAN_W+1:2]};
        return s[CHAN_W-1:0];
    endfunction

endpackage

[rtl/bup4_front.sv]
module bup4_front #(
    parameter int MAX_WIDTH = bup4_pkg::MAX_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_index,
    input  logic [bup4_pkg::CFGD_W-1:0] i_cfg_data,
    input  logic                       i_accept,
    input  logic [bup4_pkg::CHAN_W-1:0] i_red,
    input  logic [bup4_pkg::CHAN_W-1:0] i_green,
    input  logic [bup4_pkg::CHAN_W-1:0] i_blue,
    input  logic [bup4_pkg::Q_CW-1:0]  i_q_count,
    output logic                       o_full,
    output logic                       o_push,
    output bup4_pkg::t_job             o_job
);
    import bup4_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CFGW_W-1:0] r_width;
    logic [CFGH_W-1:0] r_height;
    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    logic [PIX_W-1:0]  r_prev;
    logic [PIX_W-1:0]  r_ul;
    logic [PIX_W-1:0]  r_up;
    logic [PIX_W-1:0]  r_mem [MAX_WIDTH];

    logic              r_s1_v;
    logic [PIX_W-1:0]  r_s1_x;
    logic [PIX_W-1:0]  r_s1_prev;
    logic [ROW_W-1:0]  r_s1_row;
    logic [CW-1:0]     r_s1_col;
    logic [3:0]        r_s1_mask;

    logic [CW-1:0]     n_col;
    logic [ROW_W-1:0]  n_row;
    logic [CMP_W-1:0]  w_eff;
    logic [CMP_W-1:0]  h_eff;
    logic              end_row;
    logic              last_row;
    logic              has_up;
    logic              has_left;
    logic [PIX_W-1:0]  x;
    logic [3:0]        mask;

    assign x = {i_red, i_green, i_blue};

    // Configuration writes; the port never stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFGW_W'(WIDTH_RST);
            r_height <= CFGH_W'(HEIGHT_RST);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data[CFGW_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_height <= r_height;
            endcase
        end
    end

    // Effective geometry: zero acts as one, oversize is clamped.
    always_comb begin
        w_eff = CMP_W'(r_width);
        if (r_width == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(r_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        h_eff = CMP_W'(r_height);
        if (r_height == '0) begin
            h_eff = CMP_W'(1);
        end else if (CMP_W'(r_height) > CMP_W'(MAX_HEIGHT)) begin
            h_eff = CMP_W'(MAX_HEIGHT);
        end
    end

    // Classify the pixel: which blocks it completes.
    always_comb begin
        end_row  = (CMP_W'(r_col) + CMP_W'(1)) >= w_eff;
        last_row = (CMP_W'(r_row) + CMP_W'(1)) >= h_eff;
        has_up   = (r_row != '0);
        has_left = (r_col != '0);
        mask[BLK_INNER]  = has_up && has_left;
        mask[BLK_RIGHT]  = has_up && end_row;
        mask[BLK_BOTTOM] = last_row && has_left;
        mask[BLK_CORNER] = last_row && end_row;
        n_col = end_row ? '0 : r_col + CW'(1);
        n_row = r_row;
        if (end_row) begin
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end
    end

    // Position counters and the pixel to the left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_prev <= '0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_prev <= x;
        end
    end

    // Line buffer: read the pixel above, then overwrite it with this one.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_up         <= r_mem[r_col];
            r_mem[r_col] <= x;
        end
    end

    // Second stage holds the pixel while the line buffer read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_x    <= x;
            r_s1_prev <= r_prev;
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_s1_mask <= mask;
        end
    end

    // The upper-left pixel is the previous pixel's upper neighbor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ul <= '0;
        end else if (r_s1_v) begin
            r_ul <= r_up;
        end
    end

    // Hand the job to the queue; pixels that complete no block are dropped.
    always_comb begin
        o_job.x    = r_s1_x;
        o_job.up   = r_up;
        o_job.ul   = r_ul;
        o_job.prev = r_s1_prev;
        o_job.row  = r_s1_row;
        o_job.col  = COL_W'(r_s1_col);
        o_job.mask = r_s1_mask;
    end

    assign o_push = r_s1_v && (r_s1_mask != 4'd0);

    // Room must remain for the job still in the second stage.
    assign o_full = ({1'b0, i_q_count} + (Q_CW+1)'(r_s1_v)) >= (Q_CW+1)'(Q_DEPTH);

endmodule

[rtl/bup4_queue.sv]
module bup4_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  bup4_pkg::t_job            i_job,
    input  logic                      i_pop,
    output bup4_pkg::t_job            o_head,
    output logic                      o_valid,
    output logic [bup4_pkg::Q_CW-1:0] o_count
);
    import bup4_pkg::*;

    t_job            r_ent [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_cnt <= r_cnt + Q_CW'(i_push) - Q_CW'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

    assign o_head  = r_ent[r_rp];
    assign o_valid = (r_cnt != '0);
    assign o_count = r_cnt;

endmodule

[rtl/bup4_back.sv]
module bup4_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bup4_pkg::t_job              i_job,
    input  logic                        i_job_valid,
    output logic                        o_job_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [bup4_pkg::CHAN_W-1:0] o_out_red,
    output logic [bup4_pkg::CHAN_W-1:0] o_out_green,
    output logic [bup4_pkg::CHAN_W-1:0] o_out_blue,
    output logic [bup4_pkg::OROW_W-1:0] o_out_row,
    output logic [bup4_pkg::OCOL_W-1:0] o_out_col,
    output logic                        o_run_last
);
    import bup4_pkg::*;

    logic [3:0]        r_done;
    logic [3:0]        r_pix;
    logic              r_ov;
    logic [PIX_W-1:0]  r_rgb;
    logic [OROW_W-1:0] r_orow;
    logic [OCOL_W-1:0] r_ocol;
    logic              r_last;

    logic [3:0]        pend;
    logic [3:0]        blk;
    logic              last_blk;
    logic              step;
    logic              blk_end;
    logic [1:0]        dx;
    logic [1:0]        dy;
    logic [PIX_W-1:0]  ca, cb, cc, cd;
    logic [ROW_W-1:0]  br;
    logic [COL_W-1:0]  bc;
    logic [PIX_W-1:0]  rgb;
    logic [CHAN_W-1:0] top;
    logic [CHAN_W-1:0] bot;

    assign dx = r_pix[1:0];
    assign dy = r_pix[3:2];

    // Pick the lowest block of the head job not yet sent.
    always_comb begin
        pend = i_job.mask & ~r_done;
        blk  = 4'd0;
        if (pend[BLK_INNER]) begin
            blk[BLK_INNER] = 1'b1;
        end else if (pend[BLK_RIGHT]) begin
            blk[BLK_RIGHT] = 1'b1;
        end else if (pend[BLK_BOTTOM]) begin
            blk[BLK_BOTTOM] = 1'b1;
        end else begin
            blk[BLK_CORNER] = 1'b1;
        end
        last_blk = (pend & ~blk) == 4'd0;
    end

    // Corners and block position for the chosen block.
    always_comb begin
        ca = i_job.x;
        cb = i_job.x;
        cc = i_job.x;
        cd = i_job.x;
        br = i_job.row;
        bc = i_job.col;
        if (blk[BLK_INNER]) begin
            ca = i_job.ul;
            cb = i_job.up;
            cc = i_job.prev;
            br = i_job.row - ROW_W'(1);
            bc = i_job.col - COL_W'(1);
        end else if (blk[BLK_RIGHT]) begin
            ca = i_job.up;
            cb = i_job.up;
            br = i_job.row - ROW_W'(1);
        end else if (blk[BLK_BOTTOM]) begin
            ca = i_job.prev;
            cc = i_job.prev;
            bc = i_job.col - COL_W'(1);
        end
    end

    // Horizontal then vertical interpolation, per channel.
    always_comb begin
        rgb = '0;
        top = '0;
        bot = '0;
        for (int ch = 0; ch < 3; ch++) begin
            top = f_lerp(ca[ch*CHAN_W +: CHAN_W], cb[ch*CHAN_W +: CHAN_W], dx);
            bot = f_lerp(cc[ch*CHAN_W +: CHAN_W], cd[ch*CHAN_W +: CHAN_W], dx);
            rgb[ch*CHAN_W +: CHAN_W] = f_lerp(top, bot, dy);
        end
    end

    assign step      = i_job_valid && (!r_ov || i_pop);
    assign blk_end   = (r_pix == 4'hF);
    assign o_job_pop = step && blk_end && last_blk;

    // Block and pixel sequencing over the head job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            r_pix  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (step) begin
                r_pix <= r_pix + 4'd1;
                r_ov  <= 1'b1;
                if (blk_end) begin
                    r_done <= last_blk ? 4'd0 : (r_done | blk);
                end
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Output register; it is loaded when a job is waiting and it is free or being taken.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_rgb  <= rgb;
            r_orow <= {br, dy};
            r_ocol <= OCOL_W'({bc, dx});
            r_last <= blk_end && last_blk;
        end
    end

    assign o_empty     = !r_ov;
    assign o_out_red   = r_rgb[2*CHAN_W +: CHAN_W];
    assign o_out_green = r_rgb[CHAN_W +: CHAN_W];
    assign o_out_blue  = r_rgb[0 +: CHAN_W];
    assign o_out_row   = r_orow;
    assign o_out_col   = r_ocol;
    assign o_run_last  = r_last;

endmodule

[rtl/bilinear_upscale_by_four_top.sv]
// Path: a pixel goes through the second-stage register, job queue and output register.
// Throughput: one result beat per cycle from the back end while the output is taken;
// a pixel yields 0, 16, 32 or 64 results, 16 per output block it completes. Inputs are
// taken every cycle until the four-entry job queue fills.
// Reset: synchronous, active low; clears counters, neighbors, queue and output state.
// The line buffer is not cleared.
module bilinear_upscale_by_four_top #(
    parameter int MAX_WIDTH = bup4_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [bup4_pkg::CFGD_W-1:0] i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [bup4_pkg::CHAN_W-1:0] i_red,
    input  logic [bup4_pkg::CHAN_W-1:0] i_green,
    input  logic [bup4_pkg::CHAN_W-1:0] i_blue,
    output logic                        empty,
    input  logic                        pop,
    output logic [bup4_pkg::CHAN_W-1:0] o_out_red,
    output logic [bup4_pkg::CHAN_W-1:0] o_out_green,
    output logic [bup4_pkg::CHAN_W-1:0] o_out_blue,
    output logic [bup4_pkg::OROW_W-1:0] o_out_row,
    output logic [bup4_pkg::OCOL_W-1:0] o_out_col,
    output logic                        o_run_last
);
    import bup4_pkg::*;

    t_job            push_job;
    t_job            head_job;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    logic [Q_CW-1:0] q_count;
    logic            in_accept;
    logic            out_accept;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !full;
    assign out_accept  = pop && !empty;

    // Front end: geometry, line buffer and classification.
    bup4_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_q_count   (q_count),
        .o_full      (full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    // Job queue between the two ends.
    bup4_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_head  (head_job),
        .o_valid (q_valid),
        .o_count (q_count)
    );

    // Back end: interpolation and result sequencing.
    bup4_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (q_valid),
        .o_job_pop   (q_pop),
        .i_pop       (out_accept),
        .o_empty     (empty),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_run_last  (o_run_last)
    );

endmodule
